FILE: sv/php_pkg.sv
// Shared types and constants for the packet header parser.
// Used by php_front, php_queue, php_back and packet_header_parser.
// No dependencies.
`default_nettype none

package php_pkg;

    // Default width of byte positions inside a packet
    localparam int LENGTH_BITS_DEF = 16;

    // Output field widths
    localparam int POS_W  = 16;
    localparam int PORT_W = 16;

    // Header layout
    localparam int          ETH_LEN     = 14;
    localparam int          VLAN_LEN    = 4;
    localparam int          IPV4_MIN    = 20;
    localparam int          TCP_MIN     = 20;
    localparam int          UDP_LEN     = 8;
    localparam int          ICMP_LEN    = 2;
    localparam logic [15:0] TYPE_VLAN   = 16'h8100;
    localparam logic [15:0] TYPE_IPV4   = 16'h0800;
    localparam logic [3:0]  IP_VERSION4 = 4'd4;
    localparam logic [3:0]  WORDS_MIN   = 4'd5;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Class flags
    localparam logic [3:0] FLAG_IPV4 = 4'h1;
    localparam logic [3:0] FLAG_TCP  = 4'h2;
    localparam logic [3:0] FLAG_UDP  = 4'h4;
    localparam logic [3:0] FLAG_ICMP = 4'h8;

    // Descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Output request packing
    localparam int OUT_BITS = 2 * POS_W + 8 + 4 + 2 * PORT_W + 8 + 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Raw per-packet descriptor from the front
    typedef struct packed {
        logic              ok;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  len;
        logic [7:0]        protocol;
        logic [3:0]        flags;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] dport;
        logic [15:0]       icmp;
    } desc_t;

endpackage

`default_nettype wire

FILE: sv/php_front.sv
// Front end: walks the header one byte per cycle while take is high and builds a
// descriptor on the last byte of each packet. Depends on php_pkg.
`default_nettype none

module php_front
    import php_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            push,
    output desc_t           push_desc
);

    localparam int LW = LENGTH_BITS;
    localparam int HW = LENGTH_BITS + 1;
    localparam logic [LW-1:0] POS_MAX = '1;

    // Parse phases
    localparam logic [2:0] PH_ETH  = 3'd0;
    localparam logic [2:0] PH_VLAN = 3'd1;
    localparam logic [2:0] PH_IP   = 3'd2;
    localparam logic [2:0] PH_L4   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [LW-1:0] pos_reg,       pos_next;
    logic [2:0]    phase_reg,     phase_next;
    logic [15:0]   type_reg,      type_next;
    logic [LW-1:0] ip_start_reg,  ip_start_next;
    logic [LW-1:0] l4_start_reg,  l4_start_next;
    logic [LW-1:0] hdr_end_reg,   hdr_end_next;
    logic [7:0]    proto_reg,     proto_next;
    logic [15:0]   src_reg,       src_next;
    logic [15:0]   dst_reg,       dst_next;
    logic [15:0]   icmp_reg,      icmp_next;
    logic [3:0]    flags_reg,     flags_next;
    logic          failed_reg,    failed_next;

    logic [HW-1:0] he_w;
    logic [HW-1:0] seg_w;
    logic          type_done;
    logic          seg_bad;
    logic [LW-1:0] rel_ip;
    logic [LW-1:0] rel_l4;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] len;
    logic [5:0]    ihl_bytes;
    logic [5:0]    doff_bytes;
    logic          has_ports;

    // Per-byte header step
    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        type_next     = type_reg;
        ip_start_next = ip_start_reg;
        l4_start_next = l4_start_reg;
        proto_next    = proto_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        icmp_next     = icmp_reg;
        flags_next    = flags_reg;
        failed_next   = failed_reg;
        he_w          = {1'b0, hdr_end_reg};
        seg_w         = '0;
        type_done     = 1'b0;
        seg_bad       = 1'b0;
        rel_ip        = pos_reg - ip_start_reg;
        rel_l4        = pos_reg - l4_start_reg;
        pos_inc       = pos_reg + LW'(1);
        ihl_bytes     = {data_byte[3:0], 2'b00};
        doff_bytes    = {data_byte[7:4], 2'b00};
        has_ports     = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP);

        if (!failed_reg && phase_reg != PH_DONE)
        begin
            if (pos_reg == POS_MAX)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_ETH:
                    begin
                        if (pos_reg == LW'(12))
                        begin
                            type_next = {data_byte, 8'h00};
                        end
                        else if (pos_reg == LW'(13))
                        begin
                            type_next = {type_reg[15:8], data_byte};
                            seg_w     = HW'(ETH_LEN);
                            type_done = 1'b1;
                        end
                    end
                    PH_VLAN:
                    begin
                        if (rel_ip == LW'(2))
                        begin
                            type_next = {data_byte, 8'h00};
                        end
                        else if (rel_ip == LW'(3))
                        begin
                            type_next = {type_reg[15:8], data_byte};
                            seg_w     = {1'b0, hdr_end_reg};
                            type_done = 1'b1;
                        end
                    end
                    PH_IP:
                    begin
                        if (rel_ip == '0)
                        begin
                            if (data_byte[7:4] != IP_VERSION4 || data_byte[3:0] < WORDS_MIN)
                            begin
                                failed_next = 1'b1;
                                seg_bad     = 1'b1;
                            end
                            else
                            begin
                                he_w = {1'b0, ip_start_reg} + HW'(ihl_bytes);
                            end
                        end
                        else if (rel_ip == LW'(9))
                        begin
                            proto_next = data_byte;
                        end
                        // End of the IPv4 header: pick the L4 header length
                        if (!seg_bad && {1'b0, pos_inc} == he_w)
                        begin
                            l4_start_next = he_w[LW-1:0];
                            flags_next    = FLAG_IPV4;
                            if (proto_next == PROTO_TCP)
                            begin
                                he_w       = he_w + HW'(TCP_MIN);
                                phase_next = PH_L4;
                            end
                            else if (proto_next == PROTO_UDP)
                            begin
                                he_w       = he_w + HW'(UDP_LEN);
                                phase_next = PH_L4;
                            end
                            else if (proto_next == PROTO_ICMP)
                            begin
                                he_w       = he_w + HW'(ICMP_LEN);
                                phase_next = PH_L4;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_L4:
                    begin
                        if (has_ports)
                        begin
                            if (rel_l4 == '0)
                                src_next = {data_byte, 8'h00};
                            else if (rel_l4 == LW'(1))
                                src_next = {src_reg[15:8], data_byte};
                            else if (rel_l4 == LW'(2))
                                dst_next = {data_byte, 8'h00};
                            else if (rel_l4 == LW'(3))
                                dst_next = {dst_reg[15:8], data_byte};
                        end
                        else
                        begin
                            if (rel_l4 == '0)
                                icmp_next = {data_byte, 8'h00};
                            else if (rel_l4 == LW'(1))
                                icmp_next = {icmp_reg[15:8], data_byte};
                        end
                        // TCP data offset sets the real header end
                        if (proto_reg == PROTO_TCP && rel_l4 == LW'(12))
                        begin
                            if (data_byte[7:4] < WORDS_MIN)
                            begin
                                failed_next = 1'b1;
                                seg_bad     = 1'b1;
                            end
                            else
                            begin
                                he_w = {1'b0, l4_start_reg} + HW'(doff_bytes);
                            end
                        end
                        if (!seg_bad && {1'b0, pos_inc} == he_w)
                        begin
                            if (proto_reg == PROTO_TCP)
                                flags_next = flags_reg | FLAG_TCP;
                            else if (proto_reg == PROTO_UDP)
                                flags_next = flags_reg | FLAG_UDP;
                            else
                                flags_next = flags_reg | FLAG_ICMP;
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase

                // EtherType decides the next segment
                if (type_done)
                begin
                    ip_start_next = seg_w[LW-1:0];
                    if (type_next == TYPE_VLAN)
                    begin
                        he_w       = seg_w + HW'(VLAN_LEN);
                        phase_next = PH_VLAN;
                    end
                    else if (type_next == TYPE_IPV4)
                    begin
                        he_w       = seg_w + HW'(IPV4_MIN);
                        phase_next = PH_IP;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end

                // Header end past the last countable position
                if (he_w[LW])
                    failed_next = 1'b1;
            end
        end

        hdr_end_next = he_w[LW-1:0];
        pos_next     = (pos_reg == POS_MAX) ? pos_reg : pos_inc;
        len          = (pos_reg == POS_MAX) ? POS_MAX : pos_inc;
    end

    // Descriptor for the queue
    always_comb
    begin
        push               = take && last_byte;
        push_desc.ok       = !failed_next && (phase_next == PH_DONE);
        push_desc.start    = POS_W'(hdr_end_next);
        push_desc.len      = POS_W'(len);
        push_desc.protocol = proto_next;
        push_desc.flags    = flags_next;
        push_desc.sport    = src_next;
        push_desc.dport    = dst_next;
        push_desc.icmp     = icmp_next;
    end

    // Parser state; cleared after the last byte of each packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_ETH;
            type_reg     <= '0;
            ip_start_reg <= LW'(ETH_LEN);
            l4_start_reg <= '0;
            hdr_end_reg  <= '0;
            proto_reg    <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            icmp_reg     <= '0;
            flags_reg    <= '0;
            failed_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg      <= '0;
                phase_reg    <= PH_ETH;
                type_reg     <= '0;
                ip_start_reg <= LW'(ETH_LEN);
                l4_start_reg <= '0;
                hdr_end_reg  <= '0;
                proto_reg    <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
                icmp_reg     <= '0;
                flags_reg    <= '0;
                failed_reg   <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                type_reg     <= type_next;
                ip_start_reg <= ip_start_next;
                l4_start_reg <= l4_start_next;
                hdr_end_reg  <= hdr_end_next;
                proto_reg    <= proto_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
                icmp_reg     <= icmp_next;
                flags_reg    <= flags_next;
                failed_reg   <= failed_next;
            end
        end
    end

`ifndef SYNTH
    // Done is reached only through a complete IPv4 header
    a_done_has_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> flags_reg[0])
        else $error("done phase without ipv4 flag");

    // L4 class flags are set only together with the done phase
    a_l4_flag_done: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg[1] || flags_reg[2] || flags_reg[3]) |-> (phase_reg == PH_DONE))
        else $error("l4 flag outside done phase");

    // Parser restarts after every last byte
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == '0 && phase_reg == PH_ETH && !failed_reg))
        else $error("parser not restarted after last byte");
`endif

endmodule

`default_nettype wire

FILE: sv/php_queue.sv
// Short descriptor queue between parser front and output back end.
// Depends on php_pkg.
`default_nettype none

module php_queue
    import php_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head_desc
);

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 do_push;
    logic                 do_pop;

    // Status
    always_comb
    begin
        full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_desc  = entry_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
        count_next = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    // Upstream holds off while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor pushed into full queue");

    // Fill count tracks the pointer distance
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH)) &&
        (QUEUE_AW'(count_reg) == QUEUE_AW'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count out of step with pointers");
`endif

endmodule

`default_nettype wire

FILE: sv/php_back.sv
// Back end: formats queued descriptors into result requests and holds
// them in the output register. Depends on php_pkg.
`default_nettype none

module php_back
    import php_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire desc_t           head_desc,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [OUT_W-1:0]     out_data
);

    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  length;
    logic [7:0]        protocol;
    logic [3:0]        flags;
    logic [PORT_W-1:0] out_sport;
    logic [PORT_W-1:0] out_dport;
    logic [7:0]        icmp_kind;
    logic [7:0]        icmp_subcode;
    logic              has_ports;
    logic              has_icmp;
    logic              valid_reg;
    logic [OUT_W-1:0]  data_reg;

    // Result formatting; failures give the whole packet as payload
    always_comb
    begin
        has_ports = |(head_desc.flags & (FLAG_TCP | FLAG_UDP));
        has_icmp  = |(head_desc.flags & FLAG_ICMP);
        if (head_desc.ok)
        begin
            start        = head_desc.start;
            length       = head_desc.len - head_desc.start;
            protocol     = head_desc.protocol;
            flags        = head_desc.flags;
            out_sport    = has_ports ? head_desc.sport : '0;
            out_dport    = has_ports ? head_desc.dport : '0;
            icmp_kind    = has_icmp ? head_desc.icmp[15:8] : 8'h00;
            icmp_subcode = has_icmp ? head_desc.icmp[7:0] : 8'h00;
        end
        else
        begin
            start        = '0;
            length       = head_desc.len;
            protocol     = 8'h00;
            flags        = 4'h0;
            out_sport    = '0;
            out_dport    = '0;
            icmp_kind    = 8'h00;
            icmp_subcode = 8'h00;
        end
        pop = head_valid && (!valid_reg || out_ready);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= OUT_W'({icmp_subcode, icmp_kind, out_dport, out_sport,
                                flags, protocol, length, start});
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/packet_header_parser.sv
// Packet header parser: Ethernet, VLAN tags, IPv4 and TCP/UDP/ICMP headers.
// Throughput: one packet byte per cycle; one descriptor per cycle at most.
// The descriptor of a packet is written into the queue at the edge that takes
// its last byte and then reaches m_axis through the output register.
// Input stalls only while the 4-entry descriptor queue is full.
// Reset clears the parser state, the queue and the output valid.
`default_nettype none

module packet_header_parser
    import php_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,  // data_byte
    input  wire logic             s_axis_tlast,  // last_byte
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // payload_start[15:0], payload_length[31:16], ip_protocol[39:32],
    // class_flags[43:40], source_port[59:44], destination_port[75:60],
    // icmp_kind[83:76], icmp_subcode[91:84], zero fill above
    output logic [OUT_W-1:0]      m_axis_tdata
);

    logic  take;
    logic  push;
    desc_t push_desc;
    logic  full;
    logic  pop;
    logic  head_valid;
    desc_t head_desc;

    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    php_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .push_desc (push_desc)
    );

    php_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    php_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Stream testbench for packet_header_parser: drives packets a byte at a time and
// checks each descriptor against a local header-parsing predictor.
// Depends on php_pkg (field widths, header constants, protocol and flag codes).
`timescale 1ns / 100ps

module tb_top;
    import php_pkg::*;

    localparam int unsigned POS_MAX     = (32'd1 << LENGTH_BITS_DEF) - 1;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 4;

    // Header walk stages of the predictor
    typedef enum logic [2:0] {HDR_ETH, HDR_VLAN, HDR_IP, HDR_L4, HDR_DONE} hdr_stage_e;

    // One descriptor, unpacked
    typedef struct packed {
        logic [15:0] payload_start;
        logic [15:0] payload_length;
        logic [7:0]  ip_protocol;
        logic [3:0]  class_flags;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  icmp_kind;
        logic [7:0]  icmp_subcode;
    } hdr_desc_t;

    // One byte request on the input stream
    typedef struct {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;   // data_byte
    logic             s_axis_tlast;   // last_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // payload_start, payload_length, ip_protocol, class_flags, source_port,
    // destination_port, icmp_kind, icmp_subcode, zero fill
    logic [OUT_W-1:0] m_axis_tdata;

    wire_byte_t  wire_bytes[$];     // bytes waiting to go out
    hdr_desc_t   desc_due[$];       // descriptors still to arrive
    logic [7:0]  pkt_build[$];      // packet under construction
    logic        byte_taken = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          checked = 0;
    int          rejected = 0;
    int          packets_sent = 0;
    int          bytes_sent = 0;
    int          longest_pkt = 0;

    // Predictor state
    int unsigned hp_pos;
    int unsigned hp_seg;
    int unsigned hp_l4;
    int unsigned hp_end;
    hdr_stage_e  hp_stage;
    logic [15:0] hp_etype;
    logic [7:0]  hp_proto;
    logic [15:0] hp_sport;
    logic [15:0] hp_dport;
    logic [15:0] hp_icmp;
    logic [3:0]  hp_flags;
    logic        hp_failed;

    packet_header_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Header parsing predictor
    // ---------------------------------------------------------------
    task automatic parser_clear();
        hp_pos    = 0;
        hp_stage  = HDR_ETH;
        hp_etype  = '0;
        hp_seg    = ETH_LEN;
        hp_l4     = 0;
        hp_end    = 0;
        hp_proto  = '0;
        hp_sport  = '0;
        hp_dport  = '0;
        hp_icmp   = '0;
        hp_flags  = '0;
        hp_failed = 1'b0;
    endtask

    // EtherType known: open the next segment starting at seg
    task automatic parser_segment(input int unsigned seg);
        hp_seg = seg;
        if (hp_etype == TYPE_VLAN)
        begin
            hp_end   = seg + VLAN_LEN;
            hp_stage = HDR_VLAN;
        end
        else if (hp_etype == TYPE_IPV4)
        begin
            hp_end   = seg + IPV4_MIN;
            hp_stage = HDR_IP;
        end
        else
            hp_failed = 1'b1;
        if (hp_end > POS_MAX)
            hp_failed = 1'b1;
    endtask

    // IPv4 header complete: pick the L4 header length
    task automatic parser_ip_end();
        hp_l4    = hp_end;
        hp_flags = FLAG_IPV4;
        if (hp_proto == PROTO_TCP)
        begin
            hp_end   = hp_l4 + TCP_MIN;
            hp_stage = HDR_L4;
        end
        else if (hp_proto == PROTO_UDP)
        begin
            hp_end   = hp_l4 + UDP_LEN;
            hp_stage = HDR_L4;
        end
        else if (hp_proto == PROTO_ICMP)
        begin
            hp_end   = hp_l4 + ICMP_LEN;
            hp_stage = HDR_L4;
        end
        else
            hp_stage = HDR_DONE;
        if (hp_end > POS_MAX)
            hp_failed = 1'b1;
    endtask

    task automatic parser_l4(input int unsigned rel, input logic [7:0] b);
        logic        has_ports;
        int unsigned doff;
        has_ports = (hp_proto == PROTO_TCP) || (hp_proto == PROTO_UDP);
        if (has_ports)
        begin
            if (rel == 0)      hp_sport = {b, 8'h00};
            else if (rel == 1) hp_sport = hp_sport | {8'h00, b};
            else if (rel == 2) hp_dport = {b, 8'h00};
            else if (rel == 3) hp_dport = hp_dport | {8'h00, b};
        end
        else
        begin
            if (rel == 0)      hp_icmp = {b, 8'h00};
            else if (rel == 1) hp_icmp = hp_icmp | {8'h00, b};
        end
        // TCP data offset decides the real header end
        if (hp_proto == PROTO_TCP && rel == 12)
        begin
            doff = int'(b[7:4]) * 4;
            if (doff < TCP_MIN)
            begin
                hp_failed = 1'b1;
                return;
            end
            hp_end = hp_l4 + doff;
            if (hp_end > POS_MAX)
            begin
                hp_failed = 1'b1;
                return;
            end
        end
        if (hp_pos + 1 == hp_end)
        begin
            if (hp_proto == PROTO_TCP)      hp_flags = hp_flags | FLAG_TCP;
            else if (hp_proto == PROTO_UDP) hp_flags = hp_flags | FLAG_UDP;
            else                            hp_flags = hp_flags | FLAG_ICMP;
            hp_stage = HDR_DONE;
        end
    endtask

    task automatic parser_byte(input logic [7:0] b);
        int unsigned rel;
        int unsigned ihl;
        if (hp_stage == HDR_DONE)
            return;
        if (hp_pos >= POS_MAX)
        begin
            hp_failed = 1'b1;
            return;
        end
        case (hp_stage)
            HDR_ETH:
            begin
                if (hp_pos == 12)
                    hp_etype = {b, 8'h00};
                else if (hp_pos == 13)
                begin
                    hp_etype = hp_etype | {8'h00, b};
                    parser_segment(ETH_LEN);
                end
            end
            HDR_VLAN:
            begin
                rel = hp_pos - hp_seg;
                if (rel == 2)
                    hp_etype = {b, 8'h00};
                else if (rel == 3)
                begin
                    hp_etype = hp_etype | {8'h00, b};
                    parser_segment(hp_end);
                end
            end
            HDR_IP:
            begin
                rel = hp_pos - hp_seg;
                if (rel == 0)
                begin
                    ihl = int'(b[3:0]) * 4;
                    if (b[7:4] != IP_VERSION4 || ihl < IPV4_MIN)
                    begin
                        hp_failed = 1'b1;
                        return;
                    end
                    hp_end = hp_seg + ihl;
                    if (hp_end > POS_MAX)
                    begin
                        hp_failed = 1'b1;
                        return;
                    end
                end
                else if (rel == 9)
                    hp_proto = b;
                if (hp_pos + 1 == hp_end)
                    parser_ip_end();
            end
            HDR_L4:
                parser_l4(hp_pos - hp_l4, b);
            default:
                hp_failed = 1'b1;
        endcase
    endtask

    // One accepted byte; on the last byte produce the descriptor
    task automatic parser_step(input logic [7:0] b, input logic last,
                               output logic got, output hdr_desc_t d);
        int unsigned total;
        if (!hp_failed)
            parser_byte(b);
        total = hp_pos + 1;
        if (total > POS_MAX)
            total = POS_MAX;
        if (hp_pos < POS_MAX)
            hp_pos++;
        got = last;
        d   = '0;
        if (last)
        begin
            if (!hp_failed && hp_stage == HDR_DONE)
            begin
                d.payload_start  = hp_end[15:0];
                d.payload_length = (total >= hp_end) ? 16'(total - hp_end) : 16'd0;
                d.ip_protocol    = hp_proto;
                d.class_flags    = hp_flags;
                if ((hp_flags & (FLAG_TCP | FLAG_UDP)) != 0)
                begin
                    d.source_port      = hp_sport;
                    d.destination_port = hp_dport;
                end
                if ((hp_flags & FLAG_ICMP) != 0)
                begin
                    d.icmp_kind    = hp_icmp[15:8];
                    d.icmp_subcode = hp_icmp[7:0];
                end
            end
            else
                d.payload_length = total[15:0];
            parser_clear();
        end
    endtask

    function automatic string desc_text(input hdr_desc_t d);
        return $sformatf("start=%0d len=%0d proto=%0d flags=%h sport=%h dport=%h icmp=%h/%h",
                         d.payload_start, d.payload_length, d.ip_protocol, d.class_flags,
                         d.source_port, d.destination_port, d.icmp_kind, d.icmp_subcode);
    endfunction

    // ---------------------------------------------------------------
    // Packet construction
    // ---------------------------------------------------------------
    task automatic pkt_put(input logic [7:0] b);
        pkt_build.insert(pkt_build.size(), b);
    endtask

    task automatic send_packet();
        int         n;
        wire_byte_t wb;
        n = pkt_build.size();
        for (int i = 0; i < n; i++)
        begin
            wb.data = pkt_build[i];
            wb.last = (i == n - 1);
            wire_bytes.insert(wire_bytes.size(), wb);
        end
        packets_sent++;
        bytes_sent += n;
        if (n > longest_pkt)
            longest_pkt = n;
    endtask

    // word_a/word_b: ports for TCP/UDP, word_a is type/code for ICMP.
    // cut > 0 truncates the packet to that many bytes.
    task automatic add_packet(input int vlans, input logic [15:0] etype,
                              input logic [7:0] ver_ihl, input logic [7:0] proto,
                              input logic [7:0] tcp_off, input logic [15:0] word_a,
                              input logic [15:0] word_b, input int payload, input int cut);
        int ip_len;
        int tcp_len;
        pkt_build.delete();
        repeat (12) pkt_put(8'($urandom_range(0, 255)));
        repeat (vlans)
        begin
            pkt_put(TYPE_VLAN[15:8]);
            pkt_put(TYPE_VLAN[7:0]);
            pkt_put(8'($urandom_range(0, 255)));
            pkt_put(8'($urandom_range(0, 255)));
        end
        pkt_put(etype[15:8]);
        pkt_put(etype[7:0]);
        ip_len = int'(ver_ihl[3:0]) * 4;
        if (ip_len < IPV4_MIN)
            ip_len = IPV4_MIN;
        for (int i = 0; i < ip_len; i++)
            pkt_put((i == 0) ? ver_ihl :
                    (i == 9) ? proto : 8'($urandom_range(0, 255)));
        if (proto == PROTO_TCP)
        begin
            tcp_len = int'(tcp_off[7:4]) * 4;
            if (tcp_len < TCP_MIN)
                tcp_len = TCP_MIN;
            for (int i = 0; i < tcp_len; i++)
                pkt_put((i == 0)  ? word_a[15:8] :
                        (i == 1)  ? word_a[7:0]  :
                        (i == 2)  ? word_b[15:8] :
                        (i == 3)  ? word_b[7:0]  :
                        (i == 12) ? tcp_off : 8'($urandom_range(0, 255)));
        end
        else if (proto == PROTO_UDP)
        begin
            pkt_put(word_a[15:8]);
            pkt_put(word_a[7:0]);
            pkt_put(word_b[15:8]);
            pkt_put(word_b[7:0]);
            repeat (UDP_LEN - 4) pkt_put(8'($urandom_range(0, 255)));
        end
        else if (proto == PROTO_ICMP)
        begin
            pkt_put(word_a[15:8]);
            pkt_put(word_a[7:0]);
        end
        repeat (payload) pkt_put(8'($urandom_range(0, 255)));
        while (cut > 0 && pkt_build.size() > cut)
            void'(pkt_build.pop_back());
        send_packet();
    endtask

    // Mostly well-formed headers with random content, plus broken ones and noise
    task automatic rand_packet();
        int          pick;
        int          vlans;
        int          payload;
        int          cut;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        logic [7:0]  tcp_off;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            pkt_build.delete();
            repeat ($urandom_range(1, 70)) pkt_put(8'($urandom_range(0, 255)));
            send_packet();
            return;
        end
        vlans   = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        etype   = TYPE_IPV4;
        ver_ihl = {IP_VERSION4, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : WORDS_MIN};
        case ($urandom_range(0, 9))
            0, 1, 2: proto = PROTO_TCP;
            3, 4, 5: proto = PROTO_UDP;
            6, 7:    proto = PROTO_ICMP;
            default: proto = 8'($urandom_range(0, 255));
        endcase
        tcp_off = {($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : WORDS_MIN,
                   4'($urandom_range(0, 15))};
        payload = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        cut     = 0;
        if (pick >= 80)
        begin
            case ($urandom_range(0, 4))
                0: etype = 16'($urandom_range(0, 65535));
                1: ver_ihl[7:4] = 4'($urandom_range(0, 15));
                2: ver_ihl[3:0] = 4'($urandom_range(0, 4));
                3:
                begin
                    proto = PROTO_TCP;
                    tcp_off[7:4] = 4'($urandom_range(0, 4));
                end
                default: cut = $urandom_range(1, 60);
            endcase
        end
        add_packet(vlans, etype, ver_ihl, proto, tcp_off, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), payload, cut);
    endtask

    task automatic wait_drained();
        while (wire_bytes.size() != 0 || desc_due.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus and phase control
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int phase_bytes;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        parser_clear();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            @(posedge clk);
            // pacing: none, sender idle, receiver stall, both
            send_idle_pct = (phase == 1) ? 56 : (phase == 3) ? 38 : 0;
            stall_pct     = (phase == 2) ? 56 : (phase == 3) ? 38 : 0;
            phase_bytes   = bytes_sent;
            if (phase == 0)
            begin
                // exact header end, extreme ports, longest TCP options
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0000, 16'hFFFF, 0, 0);
                add_packet(0, TYPE_IPV4, 8'h4F, PROTO_TCP, 8'hFF, 16'hFFFF, 16'h0000, 9, 0);
                // data offset below minimum
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h4A, 16'h1111, 16'h2222, 6, 0);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h0F, 16'h3333, 16'h4444, 6, 0);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 16'h1234, 16'hABCD, 0, 0);
                add_packet(1, TYPE_IPV4, 8'h46, PROTO_UDP, 8'h00, 16'h8000, 16'h0001, 5, 0);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_ICMP, 8'h00, 16'hFF00, 16'h0000, 0, 0);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_ICMP, 8'h00, 16'h00FF, 16'h0000, 8, 0);
                // protocols without an L4 header
                add_packet(0, TYPE_IPV4, 8'h45, 8'h00, 8'h00, 16'h0000, 16'h0000, 3, 0);
                add_packet(0, TYPE_IPV4, 8'h45, 8'hFF, 8'h00, 16'h0000, 16'h0000, 0, 0);
                // bad IHL, bad version
                add_packet(0, TYPE_IPV4, 8'h44, PROTO_TCP, 8'h50, 16'h0101, 16'h0202, 4, 0);
                add_packet(0, TYPE_IPV4, 8'h40, PROTO_UDP, 8'h00, 16'h0101, 16'h0202, 4, 0);
                add_packet(0, TYPE_IPV4, 8'h65, PROTO_UDP, 8'h00, 16'h0101, 16'h0202, 4, 0);
                // wrong EtherType, also behind tags; then a valid TCP header behind three tags
                add_packet(0, 16'h86DD, 8'h45, PROTO_UDP, 8'h00, 16'h0101, 16'h0202, 4, 0);
                add_packet(0, 16'h0000, 8'h45, PROTO_UDP, 8'h00, 16'h0101, 16'h0202, 0, 0);
                add_packet(2, 16'hFFFF, 8'h45, PROTO_UDP, 8'h00, 16'h0101, 16'h0202, 0, 0);
                add_packet(3, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h60, 16'hC0DE, 16'h0050, 4, 0);
                // packets that end inside a header
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0001, 16'h0002, 10, 1);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0001, 16'h0002, 10, 13);
                add_packet(2, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0001, 16'h0002, 10, 16);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0001, 16'h0002, 10, 30);
                add_packet(0, TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'h0001, 16'h0002, 10, 40);
            end
            while (bytes_sent - phase_bytes < 70)
                rand_packet();
            // sender holds off until every descriptor is back
            wait_drained();
        end

        repeat (8) @(negedge clk);
        $display("Sent %0d packets (%0d bytes, longest %0d) under four pacing mixes;",
                 packets_sent, bytes_sent, longest_pkt);
        $display("checked %0d descriptors, %0d of them rejects, %0d mismatches.",
                 checked, rejected, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: one byte request per accepted handshake, random idling
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        logic hold;
        if (rst_n)
        begin
            hold = s_axis_tvalid && !byte_taken;
            if (byte_taken)
            begin
                void'(wire_bytes.pop_front());
                byte_taken = 1'b0;
            end
            if (!hold)
            begin
                if (wire_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= wire_bytes[0].data;
                    s_axis_tlast  <= wire_bytes[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check descriptors, then predict from accepted bytes
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        hdr_desc_t seen;
        hdr_desc_t want;
        hdr_desc_t pred;
        logic      got;
        string     bad;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.payload_start    = m_axis_tdata[15:0];
                seen.payload_length   = m_axis_tdata[31:16];
                seen.ip_protocol      = m_axis_tdata[39:32];
                seen.class_flags      = m_axis_tdata[43:40];
                seen.source_port      = m_axis_tdata[59:44];
                seen.destination_port = m_axis_tdata[75:60];
                seen.icmp_kind        = m_axis_tdata[83:76];
                seen.icmp_subcode     = m_axis_tdata[91:84];
                if (desc_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR cycle %0d: descriptor with none pending: %s",
                                 cycle_count, desc_text(seen));
                end
                else
                begin
                    want = desc_due.pop_front();
                    checked++;
                    if (want.class_flags == 0)
                        rejected++;
                    bad = "";
                    if (seen.payload_start !== want.payload_start)
                        bad = {bad, " payload_start"};
                    if (seen.payload_length !== want.payload_length)
                        bad = {bad, " payload_length"};
                    if (seen.ip_protocol !== want.ip_protocol)
                        bad = {bad, " ip_protocol"};
                    if (seen.class_flags !== want.class_flags)
                        bad = {bad, " class_flags"};
                    if (seen.source_port !== want.source_port)
                        bad = {bad, " source_port"};
                    if (seen.destination_port !== want.destination_port)
                        bad = {bad, " destination_port"};
                    if (seen.icmp_kind !== want.icmp_kind)
                        bad = {bad, " icmp_kind"};
                    if (seen.icmp_subcode !== want.icmp_subcode)
                        bad = {bad, " icmp_subcode"};
                    if (bad != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR cycle %0d: descriptor %0d differs in%s",
                                     cycle_count, checked, bad);
                            $display("    expected %s", desc_text(want));
                            $display("    actual   %s", desc_text(seen));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parser_step(s_axis_tdata, s_axis_tlast, got, pred);
                if (got)
                    desc_due.insert(desc_due.size(), pred);
                byte_taken = 1'b1;
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d descriptors outstanding",
                     cycle_count, desc_due.size());
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
sv/php_pkg.sv
sv/php_front.sv
sv/php_queue.sv
sv/php_back.sv
sv/packet_header_parser.sv
tb/tb_top.sv
